/* hdl/css_pkg.sv */
// Package for the cocktail shaker sorter: data width, default capacity and
// the min/max pair type shared by the compare unit and the top level.
// No dependencies.
package css_pkg;

  localparam int unsigned CSS_DATA_W    = 32;
  localparam int unsigned CSS_MAX_ITEMS = 64;

  // ordered pair out of the compare unit
  typedef struct packed {
    logic signed [CSS_DATA_W-1:0] lo;
    logic signed [CSS_DATA_W-1:0] hi;
  } css_pair_t;

endpackage

/* hdl/css_in_if.sv */
// Input channel of the sorter: one signed element and its last-of-set mark.
// Depends on css_pkg.
interface css_in_if;
  import css_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [CSS_DATA_W-1:0] value_in;
  logic                         last_in;

  modport source (output valid, output value_in, output last_in, input ready);
  modport sink   (input valid, input value_in, input last_in, output ready);

endinterface

/* hdl/css_out_if.sv */
// Output channel of the sorter: sorted element, last mark and overflow flag.
// Depends on css_pkg.
interface css_out_if;
  import css_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [CSS_DATA_W-1:0] value_out;
  logic                         last_out;
  logic                         overflowed;

  modport source (output valid, output value_out, output last_out,
                  output overflowed, input ready);
  modport sink   (input valid, input value_out, input last_out,
                  input overflowed, output ready);

endinterface

/* hdl/css_mem.sv */
// Element store of the sorter: one write port, one read port, registered read.
// Depends on css_pkg.
module css_mem #(
  parameter int unsigned Depth = css_pkg::CSS_MAX_ITEMS,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [AddrW-1:0]                       waddr_i,
  input  logic signed [css_pkg::CSS_DATA_W-1:0]  wdata_i,
  input  logic [AddrW-1:0]                       raddr_i,
  output logic signed [css_pkg::CSS_DATA_W-1:0]  rdata_o
);
  import css_pkg::*;

  logic signed [CSS_DATA_W-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* hdl/css_minmax.sv */
// Shared compare unit of the sorter: orders two signed words into lo and hi.
// Depends on css_pkg.
module css_minmax (
  input  logic signed [css_pkg::CSS_DATA_W-1:0] a_i,
  input  logic signed [css_pkg::CSS_DATA_W-1:0] b_i,
  output css_pkg::css_pair_t                    pair_o
);
  import css_pkg::*;

  logic a_gt_b;

  // signed compare, ties keep a as the low word
  assign a_gt_b    = (a_i > b_i);
  assign pair_o.lo = a_gt_b ? b_i : a_i;
  assign pair_o.hi = a_gt_b ? a_i : b_i;

endmodule

/* hdl/cocktail_shaker_sort.sv */
// Cocktail shaker sorter, top level: sequencer, counters, output register.
// Depends on css_pkg, css_in_if, css_out_if, css_mem and css_minmax.
//
// Elements are taken one per cycle while the block is idle and written to a
// store of MAX_ITEMS entries with one write and one read port; elements past
// capacity are dropped and flag every result word of that set as overflowed.
// The word marked last starts the sort, during which no input is taken. The
// sort runs bidirectional bubble passes with one compare unit against the
// store: each compare-swap is a read state followed by a compare and
// write-back state, and each pass adds issue and take states to load the
// carried element and an end state to write it back. The sorted words then
// leave one at a time through an output register, each read, taken and held
// until the sink is ready; once the last word is accepted the next set may
// start.
module cocktail_shaker_sort #(
  parameter int unsigned MAX_ITEMS = css_pkg::CSS_MAX_ITEMS
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  css_in_if.sink    in_i,
  css_out_if.source out_o
);
  import css_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ITEMS);
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned SW = 4;

  localparam logic [SW-1:0] ST_IDLE     = 4'd0;
  localparam logic [SW-1:0] ST_D_ISSUE  = 4'd1;
  localparam logic [SW-1:0] ST_D_TAKE   = 4'd2;
  localparam logic [SW-1:0] ST_D_RD     = 4'd3;
  localparam logic [SW-1:0] ST_D_CMP    = 4'd4;
  localparam logic [SW-1:0] ST_D_END    = 4'd5;
  localparam logic [SW-1:0] ST_U_ISSUE  = 4'd6;
  localparam logic [SW-1:0] ST_U_TAKE   = 4'd7;
  localparam logic [SW-1:0] ST_U_RD     = 4'd8;
  localparam logic [SW-1:0] ST_U_CMP    = 4'd9;
  localparam logic [SW-1:0] ST_U_END    = 4'd10;
  localparam logic [SW-1:0] ST_E_RD     = 4'd11;
  localparam logic [SW-1:0] ST_E_TAKE   = 4'd12;
  localparam logic [SW-1:0] ST_E_WAIT   = 4'd13;

  logic [SW-1:0] state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic          ovf_q, ovf_d;
  logic [CW-1:0] left_q, left_d;
  logic [CW-1:0] right_q, right_d;
  logic [CW-1:0] k_q, k_d;
  logic signed [CSS_DATA_W-1:0] carry_q, carry_d;

  logic                         out_valid_q, out_valid_d;
  logic signed [CSS_DATA_W-1:0] out_value_q, out_value_d;
  logic                         out_last_q, out_last_d;
  logic                         out_ovf_q, out_ovf_d;

  logic                         mem_we;
  logic [CW-1:0]                mem_waddr, mem_raddr;
  logic signed [CSS_DATA_W-1:0] mem_wdata, mem_rdata;
  css_pair_t                    pair;

  logic          in_fire;
  logic          has_room;
  logic [CW-1:0] count_inc, left_inc, right_dec, k_dec, k_inc, left_dec;

  assign in_fire   = in_i.valid && in_i.ready;
  assign has_room  = (count_q < CW'(MAX_ITEMS));
  assign count_inc = count_q + CW'(1);
  assign left_inc  = left_q + CW'(1);
  assign left_dec  = left_q - CW'(1);
  assign right_dec = right_q - CW'(1);
  assign k_dec     = k_q - CW'(1);
  assign k_inc     = k_q + CW'(1);

  // element store
  css_mem #(
    .Depth (MAX_ITEMS),
    .AddrW (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr[AW-1:0]),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr[AW-1:0]),
    .rdata_o (mem_rdata)
  );

  // compare unit: stored word against the carried word
  css_minmax u_minmax (
    .a_i    (mem_rdata),
    .b_i    (carry_q),
    .pair_o (pair)
  );

  // sequencer and datapath control
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    left_d      = left_q;
    right_d     = right_q;
    k_d         = k_q;
    carry_d     = carry_q;
    out_valid_d = out_valid_q;
    out_value_d = out_value_q;
    out_last_d  = out_last_q;
    out_ovf_d   = out_ovf_q;
    mem_we      = 1'b0;
    mem_waddr   = count_q;
    mem_wdata   = in_i.value_in;
    mem_raddr   = k_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (has_room) begin
            mem_we  = 1'b1;
            count_d = count_inc;
          end else begin
            ovf_d = 1'b1;
          end
          if (in_i.last_in) begin
            left_d  = CW'(1);
            right_d = count_d - CW'(1);
            k_d     = '0;
            state_d = (count_d >= CW'(2)) ? ST_D_ISSUE : ST_E_RD;
          end
        end
      end
      // downward pass: carry the smaller word toward the left bound
      ST_D_ISSUE: begin
        mem_raddr = right_q;
        state_d   = ST_D_TAKE;
      end
      ST_D_TAKE: begin
        carry_d = mem_rdata;
        k_d     = right_q;
        state_d = ST_D_RD;
      end
      ST_D_RD: begin
        mem_raddr = k_dec;
        state_d   = ST_D_CMP;
      end
      ST_D_CMP: begin
        mem_we    = 1'b1;
        mem_waddr = k_q;
        mem_wdata = pair.hi;
        carry_d   = pair.lo;
        if (k_q == left_q) begin
          state_d = ST_D_END;
        end else begin
          k_d     = k_dec;
          state_d = ST_D_RD;
        end
      end
      ST_D_END: begin
        mem_we    = 1'b1;
        mem_waddr = left_dec;
        mem_wdata = carry_q;
        left_d    = left_inc;
        if (left_inc <= right_q) begin
          state_d = ST_U_ISSUE;
        end else begin
          k_d     = '0;
          state_d = ST_E_RD;
        end
      end
      // upward pass: carry the larger word toward the right bound
      ST_U_ISSUE: begin
        mem_raddr = left_dec;
        state_d   = ST_U_TAKE;
      end
      ST_U_TAKE: begin
        carry_d = mem_rdata;
        k_d     = left_q;
        state_d = ST_U_RD;
      end
      ST_U_RD: begin
        mem_raddr = k_q;
        state_d   = ST_U_CMP;
      end
      ST_U_CMP: begin
        mem_we    = 1'b1;
        mem_waddr = k_dec;
        mem_wdata = pair.lo;
        carry_d   = pair.hi;
        if (k_q == right_q) begin
          state_d = ST_U_END;
        end else begin
          k_d     = k_inc;
          state_d = ST_U_RD;
        end
      end
      ST_U_END: begin
        mem_we    = 1'b1;
        mem_waddr = right_q;
        mem_wdata = carry_q;
        right_d   = right_dec;
        if (left_q <= right_dec) begin
          state_d = ST_D_ISSUE;
        end else begin
          k_d     = '0;
          state_d = ST_E_RD;
        end
      end
      // emit sorted words through the output register
      ST_E_RD: begin
        mem_raddr = k_q;
        state_d   = ST_E_TAKE;
      end
      ST_E_TAKE: begin
        out_valid_d = 1'b1;
        out_value_d = mem_rdata;
        out_last_d  = (k_q == count_q - CW'(1));
        out_ovf_d   = ovf_q;
        state_d     = ST_E_WAIT;
      end
      ST_E_WAIT: begin
        if (out_o.ready) begin
          out_valid_d = 1'b0;
          if (out_last_q) begin
            count_d = '0;
            ovf_d   = 1'b0;
            state_d = ST_IDLE;
          end else begin
            k_d     = k_inc;
            state_d = ST_E_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    left_q      <= left_d;
    right_q     <= right_d;
    k_q         <= k_d;
    carry_q     <= carry_d;
    out_value_q <= out_value_d;
    out_last_q  <= out_last_d;
    out_ovf_q   <= out_ovf_d;
  end

  assign in_i.ready       = (state_q == ST_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.value_out  = out_value_q;
  assign out_o.last_out   = out_last_q;
  assign out_o.overflowed = out_ovf_q;

  // the block never takes input while a sorted word is pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !out_o.valid)
    else $error("input ready while output word pending");

  // the store fill count stays within capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_ITEMS))
    else $error("element count beyond capacity");

  // a last word closes the set and stops further input
  a_last_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.last_in) |=> !in_i.ready)
    else $error("input still taken after last word");

  // downward pass index stays between the bounds
  a_down_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_D_RD) |-> (k_q >= left_q && k_q <= right_q))
    else $error("downward pass index out of bounds");

endmodule

/* tb/tb_cocktail_shaker_sort.sv */
// Self-checking testbench for the cocktail shaker sorter: drives sets of signed
// words, predicts each sorted burst and checks every result word in order.
// Depends on css_pkg, css_in_if, css_out_if and the cocktail_shaker_sort RTL.
`timescale 1ns / 1ps

module tb_cocktail_shaker_sort;
  import css_pkg::*;

  localparam int unsigned W          = CSS_DATA_W;
  localparam int unsigned CAP        = CSS_MAX_ITEMS;
  localparam int unsigned RAND_WORDS = 246;
  localparam int unsigned CALM_TAIL  = 40;
  localparam int unsigned DRAIN_CYC  = 300;
  localparam longint      CYCLE_CAP  = 500_000;

  typedef struct {
    logic signed [W-1:0] value;
    bit                  last;
    bit                  ovf;
  } sorted_word_t;

  typedef struct {
    logic signed [W-1:0] value;
    bit                  last;
    bit                  typed;
    logic signed [W-1:0] sorted;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  css_in_if  in_if ();
  css_out_if out_if ();

  cocktail_shaker_sort dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // predictor state: words of the set being collected
  logic signed [W-1:0] held [CAP];
  int unsigned         held_n;
  bit                  held_ovf;
  sorted_word_t        sorted_q [$];

  bit          gaps_on;
  int unsigned errors;
  int unsigned words_in;
  int unsigned words_checked;
  int unsigned sets_done;
  int unsigned ovf_sets;
  longint      cycles;
  int          stall_left;

  stim_row_t plan [24];

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // cycle count and timeout
  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d sorted words outstanding", cycles,
               sorted_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input longint want, input longint got);
    errors++;
    $display("mismatch @%0t: %s expected %0d got %0d", $time, what, want, got);
  endtask

  // bidirectional bubble passes over the held set
  function automatic void shake_held(input int n);
    int lo;
    int hi;
    int k;
    logic signed [W-1:0] t;
    lo = 1;
    hi = n - 1;
    while (lo <= hi) begin
      for (k = hi; k >= lo; k--) begin
        if (held[k-1] > held[k]) begin
          t = held[k]; held[k] = held[k-1]; held[k-1] = t;
        end
      end
      lo++;
      for (k = lo; k <= hi; k++) begin
        if (held[k-1] > held[k]) begin
          t = held[k]; held[k] = held[k-1]; held[k-1] = t;
        end
      end
      hi--;
    end
  endfunction

  // predictor: store one word, on the last word sort and queue the burst
  function automatic void take_element(input logic signed [W-1:0] v, input bit l);
    int k;
    if (held_n < CAP) begin
      held[held_n] = v;
      held_n++;
    end else begin
      held_ovf = 1'b1;
    end
    if (l) begin
      shake_held(held_n);
      for (k = 0; k < held_n; k++)
        sorted_q.push_back('{value: held[k], last: (k == held_n - 1), ovf: held_ovf});
      if (held_ovf) ovf_sets++;
      sets_done++;
      held_n   = 0;
      held_ovf = 1'b0;
    end
  endfunction

  // send one word; entered and left at a falling edge
  task automatic drive_element(input logic signed [W-1:0] v, input bit l,
                               input bit predict, input logic signed [W-1:0] typed_v);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    in_if.valid    = 1'b1;
    in_if.value_in = v;
    in_if.last_in  = l;
    do @(posedge clk_i); while (!in_if.ready);
    words_in++;
    if (predict) begin
      take_element(v, l);
    end else begin
      sorted_q.push_back('{value: typed_v, last: 1'b1, ovf: 1'b0});
      sets_done++;
    end
    @(negedge clk_i);
  endtask

  // hold the sender until every queued result word has come out
  task automatic hold_until_drained();
    in_if.valid = 1'b0;
    wait (sorted_q.size() == 0);
    @(negedge clk_i);
  endtask

  function automatic logic signed [W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3:    return $urandom_range(0, 8) - 4;
      default: return $urandom;
    endcase
  endfunction

  // result side: random stall bursts, set up at the falling edge
  initial begin
    out_if.ready = 1'b0;
    stall_left   = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        out_if.ready = 1'b0;
        stall_left--;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        out_if.ready = 1'b0;
        stall_left   = $urandom_range(1, 7) - 1;
      end else begin
        out_if.ready = 1'b1;
      end
    end
  end

  // compare each result word with the oldest expected word
  always @(posedge clk_i) begin
    sorted_word_t exp_w;
    if (rst_ni && out_if.valid && out_if.ready) begin
      words_checked++;
      if (sorted_q.size() == 0) begin
        report_mismatch("unexpected word, value", 0, out_if.value_out);
      end else begin
        exp_w = sorted_q.pop_front();
        if (out_if.value_out !== exp_w.value)
          report_mismatch("value_out", exp_w.value, out_if.value_out);
        if (out_if.last_out !== exp_w.last)
          report_mismatch("last_out", exp_w.last, out_if.last_out);
        if (out_if.overflowed !== exp_w.ovf)
          report_mismatch("overflowed", exp_w.ovf, out_if.overflowed);
      end
    end
  end

  // stimulus
  initial begin
    int unsigned rand_sent;
    int unsigned set_idx;
    int unsigned size;
    int unsigned i;

    in_if.valid    = 1'b0;
    in_if.value_in = '0;
    in_if.last_in  = 1'b0;
    rst_ni         = 1'b0;
    gaps_on        = 1'b1;
    held_n         = 0;
    held_ovf       = 1'b0;
    errors         = 0;
    words_in       = 0;
    words_checked  = 0;
    sets_done      = 0;
    ovf_sets       = 0;

    // single-word extremes first, then mixed, reversed, sorted, equal and pair sets
    plan = '{
      '{32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF},
      '{32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000},
      '{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
      '{32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF},
      '{32'h0000_0005, 1'b0, 1'b0, 32'h0},
      '{32'hFFFF_FFFD, 1'b0, 1'b0, 32'h0},
      '{32'h0000_0005, 1'b0, 1'b0, 32'h0},
      '{32'h8000_0000, 1'b0, 1'b0, 32'h0},
      '{32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
      '{32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
      '{32'h0000_0000, 1'b1, 1'b0, 32'h0},
      '{32'h0000_0004, 1'b0, 1'b0, 32'h0},
      '{32'h0000_0003, 1'b0, 1'b0, 32'h0},
      '{32'h0000_0002, 1'b0, 1'b0, 32'h0},
      '{32'h0000_0001, 1'b1, 1'b0, 32'h0},
      '{32'hFFFF_FFFE, 1'b0, 1'b0, 32'h0},
      '{32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
      '{32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{32'h0000_0001, 1'b1, 1'b0, 32'h0},
      '{32'h0000_0007, 1'b0, 1'b0, 32'h0},
      '{32'h0000_0007, 1'b0, 1'b0, 32'h0},
      '{32'h0000_0007, 1'b1, 1'b0, 32'h0},
      '{32'h0000_0001, 1'b0, 1'b0, 32'h0},
      '{32'h0000_0000, 1'b1, 1'b0, 32'h0}
    };

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed sets
    foreach (plan[r])
      drive_element(plan[r].value, plan[r].last, !plan[r].typed, plan[r].sorted);

    // let everything drain before the random sets
    hold_until_drained();

    // random sets; one overfull set with dropped words and one exactly full set
    rand_sent = 0;
    set_idx   = 0;
    while (rand_sent < RAND_WORDS) begin
      if (set_idx == 2)      size = CAP + 3;
      else if (set_idx == 5) size = CAP;
      else if ($urandom_range(0, 5) == 0) size = $urandom_range(9, 20);
      else size = $urandom_range(1, 8);
      if (rand_sent >= RAND_WORDS - CALM_TAIL) gaps_on = 1'b0;
      else gaps_on = ($urandom_range(0, 3) != 0);
      for (i = 0; i < size; i++)
        drive_element(pick_value(), i == size - 1, 1'b1, '0);
      rand_sent += size;
      set_idx++;
    end
    in_if.valid = 1'b0;

    // drain and watch for stray words
    wait (sorted_q.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk_i);

    $display("sent %0d words in %0d sets (%0d overfull), checked %0d sorted words",
             words_in, sets_done, ovf_sets, words_checked);
    $display("covered extremes, equal values, reversed and full-capacity sets, %0d errors",
             errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* cocktail_shaker_sort.f */
hdl/css_pkg.sv
hdl/css_in_if.sv
hdl/css_out_if.sv
hdl/css_mem.sv
hdl/css_minmax.sv
hdl/cocktail_shaker_sort.sv
tb/tb_cocktail_shaker_sort.sv
